// ===== hdl/lzfsp_pkg.sv =====
`timescale 1ns / 1ps

package lzfsp_pkg;

  localparam int ZOOM_LEVELS = 8;
  localparam int IDX_W       = (ZOOM_LEVELS > 1) ? $clog2(ZOOM_LEVELS) : 1;

  localparam int LVL_W   = 4;
  localparam int DELTA_W = 13;
  localparam int POS_W   = 16;
  localparam int ZPL_W   = 10;
  localparam int GAIN_W  = 8;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 10;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_A_W   = $clog2(FIFO_DEPTH);

  localparam logic [LVL_W:0] LVL_MAX = (LVL_W + 1)'(ZOOM_LEVELS);

  localparam logic OP_ZOOM  = 1'b0;
  localparam logic OP_FOCUS = 1'b1;

  localparam logic MOTOR_ZOOM  = 1'b0;
  localparam logic MOTOR_FOCUS = 1'b1;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  localparam logic [CFG_A_W-1:0] CFG_ZOOM_PULSES = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_LAST_PULSES = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_FOCUS_GAIN  = 2'd2;

  localparam logic [ZPL_W-1:0]  RST_ZOOM_PULSES = 10'd74;
  localparam logic [ZPL_W-1:0]  RST_LAST_PULSES = 10'd35;
  localparam logic [GAIN_W-1:0] RST_FOCUS_GAIN  = 8'd3;

  localparam logic [LVL_W-1:0] RST_ZOOM_LEVEL = 4'd1;

  typedef enum logic [1:0] {
    BEAT_ZOOM,
    BEAT_HOME,
    BEAT_TARGET
  } beat_t;

  // One planned request as it travels from the front to the back.
  typedef struct packed {
    logic               is_zoom;
    logic               zoom_dir;
    logic [LVL_W-1:0]   zoom_mul;
    logic               add_last;
    logic [POS_W-1:0]   home;
    logic [POS_W-1:0]   target;
    logic [DELTA_W-1:0] focus_mag;
    logic               focus_dir;
  } plan_t;

  typedef struct packed {
    logic [ZPL_W-1:0]  zoom_pulses;
    logic [ZPL_W-1:0]  last_pulses;
    logic [GAIN_W-1:0] focus_gain;
  } cfg_t;

  function automatic logic [POS_W-1:0] default_curve(input int idx);
    logic [POS_W-1:0] v;
    case (idx)
      0:       v = 16'd0;
      1:       v = 16'd35;
      2:       v = 16'd65;
      3:       v = 16'd102;
      4:       v = 16'd148;
      5:       v = 16'd222;
      6:       v = 16'd355;
      default: v = 16'd497;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lzfsp_front.sv =====
`timescale 1ns / 1ps

module lzfsp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                op,
  input  logic [lzfsp_pkg::LVL_W-1:0]         target_zoom,
  input  logic signed [lzfsp_pkg::DELTA_W-1:0] focus_delta,
  input  logic [lzfsp_pkg::GAIN_W-1:0]        focus_gain,
  input  logic                                q_full,
  output logic                                in_ready,
  output logic                                q_push,
  output lzfsp_pkg::plan_t                    q_data
);

  logic [lzfsp_pkg::LVL_W-1:0] cur_zoom_r, cur_zoom_nxt;
  logic [lzfsp_pkg::POS_W-1:0] focus_pos_r, focus_pos_nxt;
  logic [lzfsp_pkg::POS_W-1:0] focus_tbl_r [lzfsp_pkg::ZOOM_LEVELS];

  logic                          accept;
  logic                          tz_ok;
  logic [lzfsp_pkg::IDX_W-1:0]   tbl_idx;
  logic [lzfsp_pkg::POS_W-1:0]   tbl_rd;
  logic                          up;
  logic [lzfsp_pkg::LVL_W-1:0]   hi;
  logic [lzfsp_pkg::LVL_W-1:0]   lo;
  logic [lzfsp_pkg::LVL_W-1:0]   steps;
  logic                          hi_top;
  logic [lzfsp_pkg::POS_W:0]     tgt_sum;
  logic [lzfsp_pkg::POS_W-1:0]   target;
  logic                          neg;
  logic [lzfsp_pkg::DELTA_W-1:0] mag;
  logic [lzfsp_pkg::POS_W:0]     pos_sum;
  logic [lzfsp_pkg::POS_W-1:0]   pos_mag;
  logic [lzfsp_pkg::POS_W-1:0]   new_pos;
  logic                          zoom_go;
  logic                          focus_go;
  logic                          tbl_we;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign tz_ok   = (target_zoom != '0) && ({1'b0, target_zoom} <= lzfsp_pkg::LVL_MAX);
  assign tbl_idx = lzfsp_pkg::IDX_W'(target_zoom - 4'd1);
  assign tbl_rd  = tz_ok ? focus_tbl_r[tbl_idx] : '0;

  assign up     = target_zoom > cur_zoom_r;
  assign hi     = up ? target_zoom : cur_zoom_r;
  assign lo     = up ? cur_zoom_r : target_zoom;
  assign steps  = hi - lo;
  assign hi_top = ({1'b0, hi} == lzfsp_pkg::LVL_MAX);

  assign tgt_sum = {1'b0, tbl_rd} + 17'(focus_gain);
  assign target  = up ? tbl_rd : (tgt_sum[lzfsp_pkg::POS_W] ? 16'hFFFF : tgt_sum[15:0]);

  assign neg     = focus_delta[lzfsp_pkg::DELTA_W-1];
  assign mag     = neg ? lzfsp_pkg::DELTA_W'(~focus_delta + 13'sd1) : focus_delta;
  assign pos_mag = 16'(mag);
  assign pos_sum = {1'b0, focus_pos_r} + 17'(mag);
  assign new_pos = neg ? ((focus_pos_r > pos_mag) ? focus_pos_r - pos_mag : '0)
                       : (pos_sum[lzfsp_pkg::POS_W] ? 16'hFFFF : pos_sum[15:0]);

  assign zoom_go  = accept && (op == lzfsp_pkg::OP_ZOOM) && tz_ok &&
                    (target_zoom != cur_zoom_r);
  assign focus_go = accept && (op == lzfsp_pkg::OP_FOCUS) && (focus_delta != '0);
  assign tbl_we   = focus_go && tz_ok;

  assign q_push = zoom_go || focus_go;

  always_comb begin
    q_data           = '0;
    q_data.is_zoom   = zoom_go;
    q_data.zoom_dir  = up ? lzfsp_pkg::DIR_REV : lzfsp_pkg::DIR_FWD;
    q_data.zoom_mul  = hi_top ? steps - 4'd1 : steps;
    q_data.add_last  = hi_top;
    q_data.home      = focus_pos_r;
    q_data.target    = zoom_go ? target : new_pos;
    q_data.focus_mag = mag;
    q_data.focus_dir = neg ? lzfsp_pkg::DIR_FWD : lzfsp_pkg::DIR_REV;
  end

  always_comb begin
    cur_zoom_nxt  = cur_zoom_r;
    focus_pos_nxt = focus_pos_r;
    if (zoom_go) begin
      cur_zoom_nxt  = target_zoom;
      focus_pos_nxt = target;
    end else if (focus_go) begin
      focus_pos_nxt = new_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_zoom_r  <= lzfsp_pkg::RST_ZOOM_LEVEL;
      focus_pos_r <= '0;
      for (int i = 0; i < lzfsp_pkg::ZOOM_LEVELS; i++) begin
        focus_tbl_r[i] <= lzfsp_pkg::default_curve(i);
      end
    end else begin
      cur_zoom_r  <= cur_zoom_nxt;
      focus_pos_r <= focus_pos_nxt;
      if (tbl_we) begin
        focus_tbl_r[tbl_idx] <= new_pos;
      end
    end
  end

endmodule

// ===== hdl/lzfsp_fifo.sv =====
`timescale 1ns / 1ps

module lzfsp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lzfsp_pkg::plan_t wr_data,
  input  logic             pop,
  output lzfsp_pkg::plan_t rd_data,
  output logic             full,
  output logic             empty
);

  lzfsp_pkg::plan_t mem_r [lzfsp_pkg::FIFO_DEPTH];

  logic [lzfsp_pkg::FIFO_A_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lzfsp_pkg::FIFO_A_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lzfsp_pkg::FIFO_A_W:0]   count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count_r == (lzfsp_pkg::FIFO_A_W + 1)'(lzfsp_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/lzfsp_back.sv =====
`timescale 1ns / 1ps

module lzfsp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lzfsp_pkg::plan_t              head,
  input  logic                          q_empty,
  input  lzfsp_pkg::cfg_t               cfg,
  input  logic                          out_ready,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic                          out_motor,
  output logic                          out_dir,
  output logic [lzfsp_pkg::POS_W-1:0]   out_pulses,
  output logic [lzfsp_pkg::POS_W-1:0]   out_pos,
  output logic                          out_last
);

  lzfsp_pkg::beat_t beat_r, beat_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        motor_r, dir_r, last_r;
  logic [lzfsp_pkg::POS_W-1:0] pulses_r, pos_r;

  logic                        load;
  logic                        final_beat;
  logic [13:0]                 zoom_prod;
  logic [14:0]                 zoom_sum;
  logic                        motor_nxt, dir_nxt, last_nxt;
  logic [lzfsp_pkg::POS_W-1:0] pulses_nxt;

  assign load       = !q_empty && (!out_valid_r || out_ready);
  assign final_beat = !head.is_zoom || (beat_r == lzfsp_pkg::BEAT_TARGET);
  assign q_pop      = load && final_beat;

  assign zoom_prod = head.zoom_mul * cfg.zoom_pulses;
  assign zoom_sum  = {1'b0, zoom_prod} + (head.add_last ? 15'(cfg.last_pulses) : 15'd0);

  always_comb begin
    beat_nxt = beat_r;
    if (load) begin
      if (final_beat) begin
        beat_nxt = lzfsp_pkg::BEAT_ZOOM;
      end else begin
        unique case (beat_r)
          lzfsp_pkg::BEAT_ZOOM: beat_nxt = lzfsp_pkg::BEAT_HOME;
          lzfsp_pkg::BEAT_HOME: beat_nxt = lzfsp_pkg::BEAT_TARGET;
          default:              beat_nxt = lzfsp_pkg::BEAT_ZOOM;
        endcase
      end
    end
  end

  always_comb begin
    motor_nxt  = lzfsp_pkg::MOTOR_FOCUS;
    dir_nxt    = head.focus_dir;
    pulses_nxt = 16'(head.focus_mag);
    last_nxt   = 1'b1;
    if (head.is_zoom) begin
      unique case (beat_r)
        lzfsp_pkg::BEAT_ZOOM: begin
          motor_nxt  = lzfsp_pkg::MOTOR_ZOOM;
          dir_nxt    = head.zoom_dir;
          pulses_nxt = 16'(zoom_sum);
          last_nxt   = 1'b0;
        end
        lzfsp_pkg::BEAT_HOME: begin
          dir_nxt    = lzfsp_pkg::DIR_FWD;
          pulses_nxt = head.home;
          last_nxt   = 1'b0;
        end
        default: begin
          dir_nxt    = lzfsp_pkg::DIR_REV;
          pulses_nxt = head.target;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= lzfsp_pkg::BEAT_ZOOM;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      motor_r  <= motor_nxt;
      dir_r    <= dir_nxt;
      pulses_r <= pulses_nxt;
      pos_r    <= head.target;
      last_r   <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_motor  = motor_r;
  assign out_dir    = dir_r;
  assign out_pulses = pulses_r;
  assign out_pos    = pos_r;
  assign out_last   = last_r;

endmodule

// ===== hdl/lens_zoom_focus_stepper_planner.sv =====
`timescale 1ns / 1ps

// Plans zoom and focus stepper moves for a two-motor lens. A zoom request to a
// new level gives three output beats (zoom move, focus home, focus to the table
// value plus the focus gain when the level goes down); a nonzero focus adjust
// gives one beat; other requests give none. The front accepts one request per
// cycle while its four-entry queue has room, and the back drains one beat per
// cycle, unless out_tready stalls it, through a registered output. A request is
// written into the queue, then its beats are registered from the queue head.
// Registers must be written only while no request is in flight.

module lens_zoom_focus_stepper_planner (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lzfsp_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [lzfsp_pkg::CFG_D_W-1:0]         cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: target_zoom[3:0], focus_delta[16:4], zero fill.
  input  logic [lzfsp_pkg::IN_DATA_W-1:0]       in_tdata,
  // Fields from bit 0: op.
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: direction[0], pulse_count[16:1], focus_position[32:17],
  // zero fill.
  output logic [lzfsp_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Fields from bit 0: motor.
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  lzfsp_pkg::cfg_t  cfg_r;
  lzfsp_pkg::plan_t push_data;
  lzfsp_pkg::plan_t head;

  logic                        q_push, q_pop, q_full, q_empty;
  logic                        dir;
  logic [lzfsp_pkg::POS_W-1:0] pulses, pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zoom_pulses <= lzfsp_pkg::RST_ZOOM_PULSES;
      cfg_r.last_pulses <= lzfsp_pkg::RST_LAST_PULSES;
      cfg_r.focus_gain  <= lzfsp_pkg::RST_FOCUS_GAIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        lzfsp_pkg::CFG_ZOOM_PULSES: cfg_r.zoom_pulses <= cfg_wdata;
        lzfsp_pkg::CFG_LAST_PULSES: cfg_r.last_pulses <= cfg_wdata;
        lzfsp_pkg::CFG_FOCUS_GAIN:  cfg_r.focus_gain  <= cfg_wdata[lzfsp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lzfsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .op          (in_tuser),
    .target_zoom (in_tdata[3:0]),
    .focus_delta (in_tdata[16:4]),
    .focus_gain  (cfg_r.focus_gain),
    .q_full      (q_full),
    .in_ready    (in_tready),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  lzfsp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lzfsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .cfg        (cfg_r),
    .out_ready  (out_tready),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_motor  (out_tuser),
    .out_dir    (dir),
    .out_pulses (pulses),
    .out_pos    (pos),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, pos, pulses, dir};

endmodule

// ===== hdl/lzfsp_checker.sv =====
`timescale 1ns / 1ps

module lzfsp_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lzfsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_zoom_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == lzfsp_pkg::MOTOR_ZOOM) |-> !out_tlast)
    else $error("zoom move marked as final move");

  a_home_follows_zoom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == lzfsp_pkg::MOTOR_ZOOM) |=>
      out_tvalid && (out_tuser == lzfsp_pkg::MOTOR_FOCUS) &&
      (out_tdata[0] == lzfsp_pkg::DIR_FWD) && !out_tlast)
    else $error("focus home move did not follow zoom move");

endmodule

bind lens_zoom_focus_stepper_planner lzfsp_port_checker u_lzfsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
